FILE: design/dbp_pkg.sv
// shared types, register indexes and helper functions for the detection box postprocess
`default_nettype none

package dbp_pkg;

    localparam int LOGIT_W    = 16;
    localparam int BOX_W      = 16;
    localparam int PX_W       = 14;
    localparam int CLASS_W    = 8;
    localparam int CONF_W     = 16;
    localparam int THRESH_W   = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int SIG_STEPS  = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_CONF       = 2'd0,
        CFG_IMAGE_WIDTH    = 2'd1,
        CFG_IMAGE_HEIGHT   = 2'd2
    } dbp_cfg_idx_t;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] class_logit;
        logic                      class_last;
        logic [BOX_W-1:0]          box_center_x;
        logic [BOX_W-1:0]          box_center_y;
        logic [BOX_W-1:0]          box_width;
        logic [BOX_W-1:0]          box_height;
    } dbp_in_t;

    typedef struct packed {
        logic [PX_W-1:0]    left_px;
        logic [PX_W-1:0]    top_px;
        logic [PX_W-1:0]    right_px;
        logic [PX_W-1:0]    bottom_px;
        logic [CLASS_W-1:0] best_class;
        logic [CONF_W-1:0]  confidence;
    } dbp_out_t;

    // sigmoid breakpoints at half-unit steps, q0.16
    function automatic logic [CONF_W-1:0] sig_entry(input logic [4:0] idx);
        logic [CONF_W-1:0] v;
        unique case (idx)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd40793;
            5'd2:    v = 16'd47911;
            5'd3:    v = 16'd53581;
            5'd4:    v = 16'd57724;
            5'd5:    v = 16'd60565;
            5'd6:    v = 16'd62428;
            5'd7:    v = 16'd63615;
            5'd8:    v = 16'd64357;
            5'd9:    v = 16'd64816;
            5'd10:   v = 16'd65097;
            5'd11:   v = 16'd65269;
            5'd12:   v = 16'd65374;
            5'd13:   v = 16'd65438;
            5'd14:   v = 16'd65476;
            5'd15:   v = 16'd65500;
            5'd16:   v = 16'd65514;
            5'd17:   v = 16'd65523;
            5'd18:   v = 16'd65528;
            5'd19:   v = 16'd65531;
            5'd20:   v = 16'd65533;
            5'd21:   v = 16'd65534;
            default: v = 16'd65535;
        endcase
        return v;
    endfunction

    // one box edge: 2*centre -/+ size in units of 2^-15, clamped to [0,1], scaled, truncated
    function automatic logic [PX_W-1:0] edge_px(
        input logic [BOX_W-1:0] centre,
        input logic [BOX_W-1:0] size,
        input logic             upper,
        input logic [PX_W-1:0]  scale
    );
        logic signed [18:0] twice_c;
        logic signed [18:0] sz;
        logic signed [18:0] v;
        logic [15:0]        c;
        logic [29:0]        p;
        twice_c = $signed({2'b00, centre, 1'b0});
        sz      = $signed({3'b000, size});
        v       = upper ? (twice_c + sz) : (twice_c - sz);
        if (v[18])
            c = 16'h0000;
        else if (v > 19'sd32768)
            c = 16'h8000;
        else
            c = v[15:0];
        p = 30'(c) * 30'(scale);
        return p[28:15];
    endfunction

endpackage

`default_nettype wire

FILE: design/dbp_sigmoid.sv
// interpolated sigmoid of a q5.10 logit, result in q0.16
`default_nettype none

module dbp_sigmoid (
    input  wire logic signed [dbp_pkg::LOGIT_W-1:0] logit,
    output logic [dbp_pkg::CONF_W-1:0]               conf
);
    import dbp_pkg::*;

    logic [LOGIT_W-1:0] mag;
    logic [6:0]         step;
    logic [8:0]         frac;
    logic               sat;
    logic [4:0]         idx;
    logic [CONF_W-1:0]  lo;
    logic [CONF_W-1:0]  hi;
    logic [CONF_W-1:0]  diff;
    logic [24:0]        prod;
    logic [CONF_W-1:0]  interp;
    logic [CONF_W-1:0]  s;
    logic [16:0]        neg_s;

    assign mag    = logit[LOGIT_W-1] ? LOGIT_W'(-logit) : LOGIT_W'(logit);
    assign step   = mag[15:9];
    assign frac   = mag[8:0];
    assign sat    = step >= 7'(SIG_STEPS);
    assign idx    = step[4:0];
    assign lo     = sig_entry(idx);
    assign hi     = sig_entry(idx + 5'd1);
    assign diff   = hi - lo;
    assign prod   = 25'(diff) * 25'(frac);
    assign interp = lo + CONF_W'(prod >> 9);
    assign s      = sat ? 16'hFFFF : interp;

    // mirror for negative logits
    assign neg_s  = 17'h10000 - {1'b0, s};
    assign conf   = logit[LOGIT_W-1] ? neg_s[CONF_W-1:0] : s;

endmodule

`default_nettype wire

FILE: design/detection_box_postprocess.sv
// top level: running arg-max over class logits, sigmoid, threshold and box denormalising
// a query's last logit is registered in stage one, and its result then in the result register
// throughput: one logit per cycle; input stalls only while the result register is held
// reset: rst_n asynchronous active low; clears query state, pipeline valids and
// sets min_conf 32768, image_width 640, image_height 480
`default_nettype none

module detection_box_postprocess #(
    parameter int MAX_CLASSES = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write port
    input  wire logic                             cfg_write,
    input  wire logic [dbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dbp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // logit stream
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire dbp_pkg::dbp_in_t                 item,
    // detections
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output dbp_pkg::dbp_out_t                     result
);
    import dbp_pkg::*;

    localparam int CNT_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    // configuration registers
    logic [THRESH_W-1:0] min_conf_reg;
    logic [PX_W-1:0]     image_width_reg;
    logic [PX_W-1:0]     image_height_reg;

    // running maximum of the current query
    logic signed [LOGIT_W-1:0] best_logit_reg, best_logit_next;
    logic [CNT_W-1:0]          best_index_reg, best_index_next;
    logic [CNT_W-1:0]          class_counter_reg, class_counter_next;

    // stage one: finished query waiting for sigmoid and box maths
    logic                      s1_valid_reg, s1_valid_next;
    logic signed [LOGIT_W-1:0] s1_logit_reg;
    logic [CNT_W-1:0]          s1_index_reg;
    logic [BOX_W-1:0]          s1_cx_reg, s1_cy_reg, s1_w_reg, s1_h_reg;

    // result register
    logic     result_valid_reg, result_valid_next;
    dbp_out_t result_reg, result_next;

    logic              accept;
    logic              out_open;
    logic              s1_advance;
    logic              take;
    logic [CONF_W-1:0] conf;
    logic              pass;

    // ---------------------------------------------------------------
    // handshake: stage one moves on whenever the result register is free
    // or its transaction completes this cycle
    // ---------------------------------------------------------------
    assign out_open   = !result_valid_reg || !result_stall;
    assign s1_advance = s1_valid_reg && out_open;
    assign item_stall = s1_valid_reg && !out_open;
    assign accept     = item_valid && !item_stall;

    // ---------------------------------------------------------------
    // configuration writes; indexes beyond the list are ignored
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_conf_reg       <= THRESH_W'(32768);
            image_width_reg    <= PX_W'(640);
            image_height_reg   <= PX_W'(480);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MIN_CONF:       min_conf_reg       <= cfg_data[THRESH_W-1:0];
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[PX_W-1:0];
                CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data[PX_W-1:0];
                default:            ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // arg-max update: the first logit of a query always wins, later
    // ones only when strictly greater, so the first class wins a tie
    // ---------------------------------------------------------------
    assign take = (class_counter_reg == '0) || (item.class_logit > best_logit_reg);

    always_comb
    begin
        best_logit_next    = best_logit_reg;
        best_index_next    = best_index_reg;
        class_counter_next = class_counter_reg;
        if (accept)
        begin
            if (item.class_last)
            begin
                // query done, back to the reset state
                best_logit_next    = 16'sh8000;
                best_index_next    = '0;
                class_counter_next = '0;
            end
            else
            begin
                if (take)
                begin
                    best_logit_next = item.class_logit;
                    best_index_next = class_counter_reg;
                end
                // counter saturates on queries with too many classes
                if (class_counter_reg < CNT_W'(MAX_CLASSES - 1))
                    class_counter_next = class_counter_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_logit_reg    <= 16'sh8000;
            best_index_reg    <= '0;
            class_counter_reg <= '0;
        end
        else
        begin
            best_logit_reg    <= best_logit_next;
            best_index_reg    <= best_index_next;
            class_counter_reg <= class_counter_next;
        end
    end

    // ---------------------------------------------------------------
    // stage one: capture winner and box on the last logit of a query
    // ---------------------------------------------------------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept && item.class_last)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.class_last)
        begin
            s1_logit_reg <= take ? item.class_logit : best_logit_reg;
            s1_index_reg <= take ? class_counter_reg : best_index_reg;
            s1_cx_reg    <= item.box_center_x;
            s1_cy_reg    <= item.box_center_y;
            s1_w_reg     <= item.box_width;
            s1_h_reg     <= item.box_height;
        end
    end

    // ---------------------------------------------------------------
    // stage two: sigmoid once on the winning logit, threshold, corners
    // ---------------------------------------------------------------
    dbp_sigmoid u_sigmoid (
        .logit (s1_logit_reg),
        .conf  (conf)
    );

    assign pass = {1'b0, conf} >= min_conf_reg;

    always_comb
    begin
        result_next.left_px    = edge_px(s1_cx_reg, s1_w_reg, 1'b0, image_width_reg);
        result_next.top_px     = edge_px(s1_cy_reg, s1_h_reg, 1'b0, image_height_reg);
        result_next.right_px   = edge_px(s1_cx_reg, s1_w_reg, 1'b1, image_width_reg);
        result_next.bottom_px  = edge_px(s1_cy_reg, s1_h_reg, 1'b1, image_height_reg);
        result_next.best_class = CLASS_W'(s1_index_reg);
        result_next.confidence = conf;
    end

    // result transaction: loaded by a passing query, dropped once taken
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (s1_advance)
            result_valid_next = pass;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && pass)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
